// File: sv/ipv4rcs_pkg.sv
// Shared types for the IPv4 range compare and split unit.
// Holds the request and response word layouts, the mode and relation codes,
// and the compare flag bundle. Depends on nothing.
`default_nettype none

package ipv4rcs_pkg;

    localparam logic [31:0] ADDR_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [31:0] ADDR_ZERO     = 32'h0000_0000;

    // Operation selected by each request word.
    typedef enum logic [1:0] {
        MODE_COMPARE    = 2'd0,
        MODE_CUT        = 2'd1,
        MODE_COMPLEMENT = 2'd2,
        MODE_JOIN       = 2'd3
    } mode_t;

    // Class of range A against range B.
    typedef enum logic [2:0] {
        REL_EQUAL     = 3'd0,
        REL_INSIDE    = 3'd1,
        REL_CONTAINS  = 3'd2,
        REL_OVL_LEFT  = 3'd3,
        REL_BELOW     = 3'd4,
        REL_OVL_RIGHT = 3'd5,
        REL_ABOVE     = 3'd6,
        REL_NONE      = 3'd7
    } relation_t;

    typedef struct packed {
        mode_t       mode;
        logic [31:0] a_lo;
        logic [31:0] a_hi;
        logic [31:0] b_lo;
        logic [31:0] b_hi;
    } req_word_t;

    typedef struct packed {
        relation_t   relation;
        logic        error;
        logic [31:0] part1_lo;
        logic [31:0] part1_hi;
        logic [31:0] part2_lo;
        logic [31:0] part2_hi;
        logic        part2_valid;
        logic [31:0] part3_lo;
        logic [31:0] part3_hi;
        logic        part3_valid;
    } rsp_word_t;

    // Endpoint comparisons shared by the classifier and the splitter.
    typedef struct packed {
        logic lo_eq;     // a_lo == b_lo
        logic hi_eq;     // a_hi == b_hi
        logic al_lt_bl;  // a_lo <  b_lo
        logic al_gt_bl;  // a_lo >  b_lo
        logic ah_lt_bh;  // a_hi <  b_hi
        logic ah_gt_bh;  // a_hi >  b_hi
        logic al_le_bh;  // a_lo <= b_hi
        logic ah_ge_bl;  // a_hi >= b_lo
    } cmp_flags_t;

endpackage

`default_nettype wire

// File: sv/ipv4rcs_classify.sv
// Endpoint comparators and relation classifier for two inclusive ranges.
// Depends on ipv4rcs_pkg for the word, flag and relation types.
`default_nettype none

module ipv4rcs_classify
    import ipv4rcs_pkg::*;
(
    input  var req_word_t  word,
    output var cmp_flags_t flags,
    output var relation_t  relation
);

    // Eight independent 32-bit compares.
    always_comb
    begin
        flags.lo_eq    = (word.a_lo == word.b_lo);
        flags.hi_eq    = (word.a_hi == word.b_hi);
        flags.al_lt_bl = (word.a_lo <  word.b_lo);
        flags.al_gt_bl = (word.a_lo >  word.b_lo);
        flags.ah_lt_bh = (word.a_hi <  word.b_hi);
        flags.ah_gt_bh = (word.a_hi >  word.b_hi);
        flags.al_le_bh = (word.a_lo <= word.b_hi);
        flags.ah_ge_bl = (word.a_hi >= word.b_lo);
    end

    // The first test that holds decides the relation.
    always_comb
    begin
        priority if (flags.lo_eq && flags.hi_eq)
            relation = REL_EQUAL;
        else if (!flags.al_lt_bl && flags.al_le_bh && !flags.ah_gt_bh)
            relation = REL_INSIDE;
        else if (!flags.al_gt_bl && !flags.ah_lt_bh)
            relation = REL_CONTAINS;
        else if (flags.al_lt_bl && flags.ah_lt_bh && flags.ah_ge_bl)
            relation = REL_OVL_LEFT;
        else if (flags.al_lt_bl && flags.ah_lt_bh)
            relation = REL_BELOW;
        else if (flags.al_gt_bl && flags.al_le_bh && flags.ah_gt_bh)
            relation = REL_OVL_RIGHT;
        else if (!flags.al_le_bh)
            relation = REL_ABOVE;
        else
            relation = REL_NONE;
    end

endmodule

`default_nettype wire

// File: sv/ipv4rcs_parts.sv
// Builds the result ranges for cut, complement and join from one request.
// Depends on ipv4rcs_pkg; takes the compare flags and relation from the classifier.
`default_nettype none

module ipv4rcs_parts
    import ipv4rcs_pkg::*;
(
    input  var req_word_t  word,
    input  var cmp_flags_t flags,
    input  var relation_t  relation,
    output var rsp_word_t  result
);

    logic [31:0] a_lo_dec;
    logic [31:0] b_lo_dec;
    logic [31:0] a_hi_inc;
    logic [31:0] b_hi_inc;
    logic        a_lo_zero;
    logic        a_hi_ones;

    // Neighbor addresses; these wrap modulo 2^32.
    assign a_lo_dec  = word.a_lo - 32'd1;
    assign b_lo_dec  = word.b_lo - 32'd1;
    assign a_hi_inc  = word.a_hi + 32'd1;
    assign b_hi_inc  = word.b_hi + 32'd1;
    assign a_lo_zero = (word.a_lo == ADDR_ZERO);
    assign a_hi_ones = (word.a_hi == ADDR_ALL_ONES);

    // Select the pieces; anything not produced stays zero.
    always_comb
    begin
        result          = '0;
        result.relation = relation;
        unique case (word.mode)
            MODE_COMPARE:
            begin
                result.error = 1'b0;
            end
            MODE_CUT:
            begin
                unique case (relation)
                    REL_OVL_LEFT:
                    begin
                        result.part1_lo    = word.a_lo;
                        result.part1_hi    = b_lo_dec;
                        result.part2_lo    = word.b_lo;
                        result.part2_hi    = word.a_hi;
                        result.part3_lo    = a_hi_inc;
                        result.part3_hi    = word.b_hi;
                        result.part2_valid = 1'b1;
                        result.part3_valid = 1'b1;
                    end
                    REL_OVL_RIGHT:
                    begin
                        result.part1_lo    = word.b_lo;
                        result.part1_hi    = a_lo_dec;
                        result.part2_lo    = word.a_lo;
                        result.part2_hi    = word.b_hi;
                        result.part3_lo    = b_hi_inc;
                        result.part3_hi    = word.a_hi;
                        result.part2_valid = 1'b1;
                        result.part3_valid = 1'b1;
                    end
                    REL_INSIDE:
                    begin
                        result.part2_valid = 1'b1;
                        priority if (flags.lo_eq)
                        begin
                            result.part1_lo = word.a_lo;
                            result.part1_hi = word.a_hi;
                            result.part2_lo = a_hi_inc;
                            result.part2_hi = word.b_hi;
                        end
                        else if (flags.hi_eq)
                        begin
                            result.part1_lo = word.b_lo;
                            result.part1_hi = a_lo_dec;
                            result.part2_lo = word.a_lo;
                            result.part2_hi = word.a_hi;
                        end
                        else
                        begin
                            result.part1_lo    = word.b_lo;
                            result.part1_hi    = a_lo_dec;
                            result.part2_lo    = word.a_lo;
                            result.part2_hi    = word.a_hi;
                            result.part3_lo    = a_hi_inc;
                            result.part3_hi    = word.b_hi;
                            result.part3_valid = 1'b1;
                        end
                    end
                    REL_CONTAINS:
                    begin
                        result.part2_valid = 1'b1;
                        priority if (flags.lo_eq)
                        begin
                            result.part1_lo = word.b_lo;
                            result.part1_hi = word.b_hi;
                            result.part2_lo = b_hi_inc;
                            result.part2_hi = word.a_hi;
                        end
                        else if (flags.hi_eq)
                        begin
                            result.part1_lo = word.a_lo;
                            result.part1_hi = b_lo_dec;
                            result.part2_lo = word.b_lo;
                            result.part2_hi = word.b_hi;
                        end
                        else
                        begin
                            result.part1_lo    = word.a_lo;
                            result.part1_hi    = b_lo_dec;
                            result.part2_lo    = word.b_lo;
                            result.part2_hi    = word.b_hi;
                            result.part3_lo    = b_hi_inc;
                            result.part3_hi    = word.a_hi;
                            result.part3_valid = 1'b1;
                        end
                    end
                    REL_EQUAL, REL_BELOW, REL_ABOVE, REL_NONE:
                    begin
                        result.error = 1'b1;
                    end
                    default:
                    begin
                        result.error = 1'b1;
                    end
                endcase
            end
            MODE_COMPLEMENT:
            begin
                priority if (!a_lo_zero && !a_hi_ones)
                begin
                    result.part1_lo    = ADDR_ZERO;
                    result.part1_hi    = a_lo_dec;
                    result.part2_lo    = a_hi_inc;
                    result.part2_hi    = ADDR_ALL_ONES;
                    result.part2_valid = 1'b1;
                end
                else if (!a_hi_ones)
                begin
                    result.part1_lo = a_hi_inc;
                    result.part1_hi = ADDR_ALL_ONES;
                end
                else if (!a_lo_zero)
                begin
                    result.part1_lo = ADDR_ZERO;
                    result.part1_hi = a_lo_dec;
                end
                else
                begin
                    // Complement of the full space is empty.
                    result.error = 1'b1;
                end
            end
            MODE_JOIN:
            begin
                result.part1_lo = flags.al_gt_bl ? word.b_lo : word.a_lo;
                result.part1_hi = flags.ah_lt_bh ? word.b_hi : word.a_hi;
            end
            default:
            begin
                result.error = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/ipv4_range_compare_and_split_unit.sv
// IPv4 range compare and split unit: input register, classifier, splitter, result register.
// Depends on ipv4rcs_pkg, ipv4rcs_classify and ipv4rcs_parts.
//
// Usage:
//   A request word on req_word carries a mode and two inclusive ranges A and B.
//   It is taken at a rising edge where req_valid is high and req_stall is low.
//   Every request yields exactly one response word on rsp_word, taken at an edge
//   where rsp_valid is high and rsp_stall is low.
//   The word is captured in the input register at the edge that takes it, the
//   compares and piece selection run on the input register's word, and the
//   response register is loaded at an edge where it can take the result, so
//   the response is offered from the response register. Throughput is one word
//   per cycle while rsp_stall is low, set by the two register stages that each
//   advance whenever the stage after them is empty or being drained.
//   When the receiver stalls, the response register holds its word and the
//   input register fills; req_stall rises once both hold a word, so at most
//   two words are in flight.
//   Reset empties both stages; nothing is produced until a new request comes.
//   The block keeps no state between words and has no configuration.
`default_nettype none

module ipv4_range_compare_and_split_unit
    import ipv4rcs_pkg::*;
(
    input  var logic      clk,
    input  var logic      rst_n,
    input  var logic      req_valid,
    output var logic      req_stall,
    input  var req_word_t req_word,
    output var logic      rsp_valid,
    input  var logic      rsp_stall,
    output var rsp_word_t rsp_word
);

    logic       in_valid_reg;
    logic       in_valid_next;
    req_word_t  in_word_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    rsp_word_t  out_word_reg;
    logic       out_advance;
    logic       in_advance;
    cmp_flags_t flags;
    relation_t  relation;
    rsp_word_t  result;

    // Stage advance: each register loads when the one after it can take its word.
    assign out_advance = !out_valid_reg || !rsp_stall;
    assign in_advance  = !in_valid_reg || out_advance;
    assign req_stall   = !in_advance;

    assign in_valid_next  = in_advance ? req_valid : in_valid_reg;
    assign out_valid_next = out_advance ? in_valid_reg : out_valid_reg;

    // Valid bits of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_advance)
        begin
            in_word_reg <= req_word;
        end
        if (out_advance)
        begin
            out_word_reg <= result;
        end
    end

    // Single pass of compare and split logic between the two registers.
    ipv4rcs_classify u_classify (
        .word     (in_word_reg),
        .flags    (flags),
        .relation (relation)
    );

    ipv4rcs_parts u_parts (
        .word     (in_word_reg),
        .flags    (flags),
        .relation (relation),
        .result   (result)
    );

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

endmodule

`default_nettype wire

// File: sv/ipv4rcs_checker.sv
// Port-level checks for the IPv4 range compare and split unit, bound to the top level.
// Depends on ipv4rcs_pkg and ipv4_range_compare_and_split_unit.
`default_nettype none

module ipv4rcs_checker
    import ipv4rcs_pkg::*;
(
    input var logic      clk,
    input var logic      rst_n,
    input var logic      rsp_valid,
    input var logic      rsp_stall,
    input var rsp_word_t rsp_word
);

    // A stalled response word stays offered.
    a_rsp_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("response valid dropped while stalled");

    // A stalled response word does not change.
    a_rsp_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp_word))
        else $error("response word changed while stalled");

    // A third piece only comes with a second one.
    a_part3_needs_part2: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.part3_valid |-> rsp_word.part2_valid)
        else $error("third range without second range");

    // An error word carries no pieces.
    a_error_clears_parts: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.error |->
            !rsp_word.part2_valid && !rsp_word.part3_valid &&
            rsp_word.part1_lo == ADDR_ZERO && rsp_word.part1_hi == ADDR_ZERO)
        else $error("error word with nonzero ranges");

    // A three-way cut only arises from an overlapping or nested relation.
    a_part3_relation: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.part3_valid |->
            rsp_word.relation == REL_OVL_LEFT || rsp_word.relation == REL_OVL_RIGHT ||
            rsp_word.relation == REL_INSIDE || rsp_word.relation == REL_CONTAINS)
        else $error("third range with unsuitable relation");

endmodule

bind ipv4_range_compare_and_split_unit ipv4rcs_checker u_checker (.*);

`default_nettype wire
